// ===== hw/rtl/adaptive_bitrate_selector_assert.svh =====
// Assertion macros for the adaptive bitrate selector
`ifndef ADAPTIVE_BITRATE_SELECTOR_ASSERT_SVH
`define ADAPTIVE_BITRATE_SELECTOR_ASSERT_SVH

// same-cycle implication
`define ABRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/abrs_pkg.sv =====
// Shared types and constants for the adaptive bitrate selector
package abrs_pkg;

    localparam int ABRS_MAX_RATES = 16;

    localparam int RATE_W  = 20;
    localparam int TPUT_W  = 40;
    localparam int BYTES_W = 24;
    localparam int TIME_W  = 32;
    localparam int ALPHA_W = 17;
    localparam int COUNT_W = 5;

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_MANIFEST = 2'd1;
    localparam logic [1:0] CMD_MEASURE  = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd32768;
    localparam logic [TPUT_W-1:0]  TPUT_MAX    = 40'hFF_FFFF_FFFF;

    // floor(bytes / 125) == (bytes * KB_RECIP) >> KB_SHIFT for all 24-bit bytes
    localparam int                KB_SHIFT = 31;
    localparam int                KBITS_W  = 18;
    localparam int                RECIP_W  = 25;
    localparam logic [RECIP_W-1:0] KB_RECIP = 25'd17179870;
    localparam int                PROD1_W  = BYTES_W + RECIP_W;

    localparam int              USEC_W       = 20;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam int              NUM_W        = KBITS_W + USEC_W + 8;
    localparam int              DIV_CNT_W    = $clog2(NUM_W + 1);

    localparam int HALF_W = TPUT_W / 2;
    localparam int PROD_W = ALPHA_W + HALF_W;
    localparam int ACC_W  = ALPHA_W + TPUT_W;

    typedef struct packed {
        logic [1:0]         command;
        logic [RATE_W-1:0]  rate_kbps;
        logic [BYTES_W-1:0] byte_count;
        logic [TIME_W-1:0]  elapsed_us;
    } item_t;

    typedef struct packed {
        logic [RATE_W-1:0]  chosen_rate_kbps;
        logic [TPUT_W-1:0]  throughput_q8;
        logic [COUNT_W-1:0] entry_count;
        logic               table_full_error;
    } result_t;

    typedef struct packed {
        logic               start;
        logic [BYTES_W-1:0] byte_count;
        logic [TIME_W-1:0]  elapsed_us;
        logic [ALPHA_W-1:0] alpha;
        logic [TPUT_W-1:0]  tput;
    } meas_req_t;

    typedef struct packed {
        logic              done;
        logic [TPUT_W-1:0] tput;
    } meas_rsp_t;

endpackage

// ===== hw/rtl/abrs_meas.sv =====
// Throughput sample and smoothing unit: reciprocal scale, serial divider, split EWMA
module abrs_meas import abrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  meas_req_t req,
    output meas_rsp_t rsp
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_KBITS,
        M_DIV,
        M_SAT,
        M_EW
    } mstate_t;

    mstate_t              state_reg, state_next;
    logic [TIME_W-1:0]    elapsed_reg, elapsed_next;
    logic [ALPHA_W-1:0]   alpha_reg, alpha_next;
    logic [TPUT_W-1:0]    tput_reg, tput_next;
    logic [PROD1_W-1:0]   prod1_reg, prod1_next;
    logic [NUM_W-1:0]     quot_reg, quot_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TPUT_W-1:0]    sample_reg, sample_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 hi_reg, hi_next;
    logic [2:0]           step_reg, step_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 done_reg, done_next;

    logic [KBITS_W-1:0]        kbits;
    logic [KBITS_W+USEC_W-1:0] kbits_us;
    logic [TIME_W:0]           shifted;
    logic [TIME_W:0]           diff;
    logic                      fits;
    logic [ALPHA_W-1:0]        one_minus_a;
    logic [ALPHA_W-1:0]        mul_a;
    logic [HALF_W-1:0]         mul_b;
    logic [ACC_W-1:0]          addend;

    always_comb
    begin
        kbits       = prod1_reg[PROD1_W-1:KB_SHIFT];
        kbits_us    = (KBITS_W+USEC_W)'(kbits) * (KBITS_W+USEC_W)'(USEC_PER_SEC);
        shifted     = {rem_reg, quot_reg[NUM_W-1]};
        diff        = shifted - {1'b0, elapsed_reg};
        fits        = shifted >= {1'b0, elapsed_reg};
        one_minus_a = ALPHA_ONE - alpha_reg;
        mul_a       = step_reg[1] ? one_minus_a : alpha_reg;
        case (step_reg[1:0])
            2'd0:    mul_b = sample_reg[HALF_W-1:0];
            2'd1:    mul_b = sample_reg[TPUT_W-1:HALF_W];
            2'd2:    mul_b = tput_reg[HALF_W-1:0];
            default: mul_b = tput_reg[TPUT_W-1:HALF_W];
        endcase
        addend = hi_reg ? ACC_W'({prod_reg, {HALF_W{1'b0}}}) : ACC_W'(prod_reg);

        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        alpha_next   = alpha_reg;
        tput_next    = tput_reg;
        prod1_next   = prod1_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        sample_next  = sample_reg;
        prod_next    = prod_reg;
        hi_next      = hi_reg;
        step_next    = step_reg;
        acc_next     = acc_reg;
        done_next    = 1'b0;

        case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    elapsed_next = req.elapsed_us;
                    alpha_next   = (req.alpha > ALPHA_ONE) ? ALPHA_ONE : req.alpha;
                    tput_next    = req.tput;
                    prod1_next   = PROD1_W'(req.byte_count) * PROD1_W'(KB_RECIP);
                    acc_next     = '0;
                    step_next    = '0;
                    if (req.elapsed_us == '0)
                    begin
                        sample_next = TPUT_MAX;
                        state_next  = M_EW;
                    end
                    else
                    begin
                        state_next = M_KBITS;
                    end
                end
            end
            M_KBITS:
            begin
                quot_next  = {kbits_us, 8'h00};
                rem_next   = '0;
                cnt_next   = DIV_CNT_W'(NUM_W);
                state_next = M_DIV;
            end
            M_DIV:
            begin
                rem_next  = fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], fits};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = M_SAT;
                end
            end
            M_SAT:
            begin
                sample_next = (|quot_reg[NUM_W-1:TPUT_W]) ? TPUT_MAX : quot_reg[TPUT_W-1:0];
                acc_next    = '0;
                step_next   = '0;
                state_next  = M_EW;
            end
            M_EW:
            begin
                if (step_reg != 3'd4)
                begin
                    prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
                    hi_next   = step_reg[0];
                end
                if (step_reg != 3'd0)
                begin
                    acc_next = acc_reg + addend;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd4)
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        alpha_reg   <= alpha_next;
        tput_reg    <= tput_next;
        prod1_reg   <= prod1_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        sample_reg  <= sample_next;
        prod_reg    <= prod_next;
        hi_reg      <= hi_next;
        step_reg    <= step_next;
        acc_reg     <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.tput = acc_reg[TPUT_W+15:16];

endmodule

// ===== hw/rtl/adaptive_bitrate_selector.sv =====
// Adaptive bitrate selector top level: sorted rate table memory and command sequencer
// One item at a time. An add walks the table from the top, reading and comparing each
// entry in turn and moving larger rates up one place; every item then scans the table
// entry by entry to pick the rate. A measure command first runs in the throughput unit,
// whose 46-bit divider gives one bit per cycle, before that scan; a zero elapsed time skips
// the divider. Manifest and unknown commands go to the scan, a manifest on a filled table
// after its lowest rate is read. The next item is taken while the previous result still waits.
`include "adaptive_bitrate_selector_assert.svh"

module adaptive_bitrate_selector import abrs_pkg::*;
#(
    parameter int MAX_RATES = ABRS_MAX_RATES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [ALPHA_W-1:0] cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result
);

    localparam int AW = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
    localparam int CW = $clog2(MAX_RATES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_MAN_WAIT,
        S_MEAS,
        S_PICK,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic               err_reg, err_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [TPUT_W-1:0]  tput_reg, tput_next;
    logic [CW-1:0]      ci_reg, ci_next;
    logic               dv_reg, dv_next;
    logic               first_reg, first_next;
    logic [RATE_W-1:0]  chosen_reg, chosen_next;
    result_t            result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    logic [RATE_W-1:0] rate_mem [MAX_RATES];
    logic [RATE_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [RATE_W-1:0] mem_wd;

    logic [CW-1:0]     k_dec;
    logic [TPUT_W-1:0] thresh;
    logic              pass;
    logic [CW+4:0]     count_ext;
    meas_req_t         meas_req;
    meas_rsp_t         meas_rsp;

    abrs_meas u_meas
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (meas_req),
        .rsp   (meas_rsp)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        k_dec     = k_reg - 1'b1;
        thresh    = TPUT_W'({rd_data_reg, 8'h00}) + TPUT_W'({rd_data_reg, 7'h00});
        pass      = thresh <= tput_reg;
        count_ext = (CW+5)'(count_reg);

        meas_req.start      = (state_reg == S_IDLE) && item_valid &&
                              (item.command == CMD_MEASURE);
        meas_req.byte_count = item.byte_count;
        meas_req.elapsed_us = item.elapsed_us;
        meas_req.alpha      = alpha_reg;
        meas_req.tput       = tput_reg;

        state_next        = state_reg;
        rate_next         = rate_reg;
        err_next          = err_reg;
        k_next            = k_reg;
        count_next        = count_reg;
        tput_next         = tput_reg;
        ci_next           = ci_reg;
        dv_next           = dv_reg;
        first_next        = first_reg;
        chosen_next       = chosen_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        rd_addr = '0;
        mem_we  = 1'b0;
        mem_wa  = k_reg[AW-1:0];
        mem_wd  = rate_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    rate_next   = item.rate_kbps;
                    err_next    = 1'b0;
                    ci_next     = '0;
                    dv_next     = 1'b0;
                    first_next  = 1'b1;
                    chosen_next = '0;
                    state_next  = S_PICK;
                    case (item.command)
                        CMD_ADD:
                        begin
                            if (count_reg == CW'(MAX_RATES))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        CMD_MANIFEST:
                        begin
                            if (count_reg == '0)
                            begin
                                tput_next = '0;
                            end
                            else
                            begin
                                state_next = S_MAN_WAIT;
                            end
                        end
                        CMD_MEASURE:
                        begin
                            state_next = S_MEAS;
                        end
                        default:
                        begin
                            state_next = S_PICK;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (k_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_PICK;
                end
                else
                begin
                    rd_addr    = k_dec[AW-1:0];
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (rd_data_reg > rate_reg)
                begin
                    mem_wd     = rd_data_reg;
                    k_next     = k_dec;
                    state_next = S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_PICK;
                end
            end
            S_MAN_WAIT:
            begin
                tput_next  = TPUT_W'({rd_data_reg, 8'h00});
                state_next = S_PICK;
            end
            S_MEAS:
            begin
                if (meas_rsp.done)
                begin
                    tput_next  = meas_rsp.tput;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (dv_reg)
                begin
                    first_next = 1'b0;
                    if (first_reg || pass)
                    begin
                        chosen_next = rd_data_reg;
                    end
                end
                if (ci_reg != count_reg)
                begin
                    rd_addr = ci_reg[AW-1:0];
                    ci_next = ci_reg + 1'b1;
                    dv_next = 1'b1;
                end
                else
                begin
                    dv_next = 1'b0;
                    if (!dv_reg)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.chosen_rate_kbps = chosen_reg;
                    result_next.throughput_q8    = tput_reg;
                    result_next.entry_count      = count_ext[COUNT_W-1:0];
                    result_next.table_full_error = err_reg;
                    result_valid_next            = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            alpha_reg        <= ALPHA_RESET;
            count_reg        <= '0;
            tput_reg         <= '0;
            result_valid_reg <= 1'b0;
            dv_reg           <= 1'b0;
            first_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_write)
            begin
                alpha_reg <= cfg_data;
            end
            count_reg        <= count_next;
            tput_reg         <= tput_next;
            result_valid_reg <= result_valid_next;
            dv_reg           <= dv_next;
            first_reg        <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg   <= rate_next;
        err_reg    <= err_next;
        k_reg      <= k_next;
        ci_reg     <= ci_next;
        chosen_reg <= chosen_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rate_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= rate_mem[rd_addr];
    end

    `ABRS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_RATES), "count over capacity")
    `ABRS_ASSERT_IMP(a_full_err, clk, rst_n, result_valid_reg && result_reg.table_full_error, count_reg == CW'(MAX_RATES), "full error with room left")
    `ABRS_ASSERT_IMP(a_write_ins, clk, rst_n, mem_we, state_reg == S_INS_RD || state_reg == S_INS_CMP, "table write outside insert")
    `ABRS_ASSERT_IMP(a_meas_done, clk, rst_n, meas_rsp.done, state_reg == S_MEAS, "stray measure completion")
    `ABRS_ASSERT_NEXT(a_ins_count, clk, rst_n, state_reg == S_INS_CMP && !(rd_data_reg > rate_reg), count_reg == $past(count_reg) + 1'b1, "insert did not grow table")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the adaptive bitrate selector: directed and random command traffic
`timescale 1ns / 1ps

module testbench import abrs_pkg::*;
;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int SEGMENT_ITEMS  = 110;
    localparam int QUIET_ITEMS    = 80;
    localparam int FILL_HOLD      = 14;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [ALPHA_W-1:0] cfg_data;
    logic               item_valid;
    logic               item_stall;
    item_t              item;
    logic               result_valid;
    logic               result_stall;
    result_t            result;

    adaptive_bitrate_selector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    logic [RATE_W-1:0]  model_rates [ABRS_MAX_RATES];
    int unsigned        model_count;
    logic [TPUT_W-1:0]  model_tput;
    logic [ALPHA_W-1:0] model_alpha;

    result_t     pending_choices [$];
    int          error_count;
    int          gap_percent;
    int          stall_percent;
    int          segment_index;
    int          recv_left;
    bit          recv_hold;
    int unsigned quiet_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic result_t predict_selection(item_t it);
        result_t     r;
        logic [63:0] bytes64;
        logic [63:0] time64;
        logic [63:0] kbits;
        logic [63:0] sample;
        logic [63:0] a;
        logic [63:0] acc;
        logic [63:0] rate64;
        int          pos;
        int          k;
        r.table_full_error = 1'b0;
        case (it.command)
            CMD_ADD:
            begin
                if (model_count >= ABRS_MAX_RATES)
                    r.table_full_error = 1'b1;
                else
                begin
                    pos = model_count;
                    while (pos > 0 && model_rates[pos - 1] > it.rate_kbps)
                    begin
                        model_rates[pos] = model_rates[pos - 1];
                        pos--;
                    end
                    model_rates[pos] = it.rate_kbps;
                    model_count++;
                end
            end
            CMD_MANIFEST:
            begin
                if (model_count == 0)
                    model_tput = '0;
                else
                    model_tput = {12'd0, model_rates[0], 8'd0};
            end
            CMD_MEASURE:
            begin
                bytes64 = it.byte_count;
                time64  = it.elapsed_us;
                kbits   = (bytes64 * 64'd8) / 64'd1000;
                if (time64 == 0)
                    sample = TPUT_MAX;
                else
                begin
                    sample = (kbits * 64'd256000000) / time64;
                    if (sample > TPUT_MAX)
                        sample = TPUT_MAX;
                end
                a = (model_alpha > ALPHA_ONE) ? ALPHA_ONE : model_alpha;
                acc = a * sample + (64'd65536 - a) * model_tput;
                acc = acc >> 16;
                if (acc > TPUT_MAX)
                    acc = TPUT_MAX;
                model_tput = acc[TPUT_W-1:0];
            end
            default:
            begin
            end
        endcase
        if (model_count == 0)
            r.chosen_rate_kbps = '0;
        else
        begin
            r.chosen_rate_kbps = model_rates[0];
            for (k = 0; k < model_count; k++)
            begin
                rate64 = model_rates[k];
                if (rate64 * 64'd384 <= model_tput)
                    r.chosen_rate_kbps = model_rates[k];
            end
        end
        r.throughput_q8 = model_tput;
        r.entry_count   = model_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic item_t make_item(logic [1:0] cmd, logic [RATE_W-1:0] rate,
                                        logic [BYTES_W-1:0] bytes, logic [TIME_W-1:0] usec);
        item_t it;
        it.command    = cmd;
        it.rate_kbps  = rate;
        it.byte_count = bytes;
        it.elapsed_us = usec;
        return it;
    endfunction

    function automatic item_t make_add(logic [RATE_W-1:0] rate);
        return make_item(CMD_ADD, rate, BYTES_W'($urandom), $urandom);
    endfunction

    function automatic item_t random_item(bit hold_fill);
        item_t       it;
        int unsigned pick;
        int unsigned mode;
        logic [63:0] target;
        logic [63:0] span;
        logic [63:0] usec;
        logic [63:0] bytes;
        it = make_item(CMD_MEASURE, RATE_W'($urandom), BYTES_W'($urandom), $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 5 && (!hold_fill || model_count < FILL_HOLD))
        begin
            it.command = CMD_ADD;
            if (model_count > 0 && $urandom_range(0, 3) == 0)
                it.rate_kbps = model_rates[$urandom_range(0, model_count - 1)];
            else if ($urandom_range(0, 1) == 0)
                it.rate_kbps = RATE_W'($urandom_range(50, 20000));
        end
        else if (pick >= 5 && pick < 13)
            it.command = CMD_MANIFEST;
        else if (pick >= 13 && pick < 17)
            it.command = CMD_UNKNOWN;
        else
        begin
            mode = $urandom_range(0, 19);
            if (mode == 0)
                it.elapsed_us = '0;
            else if (mode == 1)
                it.elapsed_us = '1;
            else if (mode > 4)
            begin
                target = $urandom_range(0, 1600000);
                span   = 64'd1 << $urandom_range(8, 20);
                usec   = $urandom_range(span / 2, span);
                bytes  = (target * usec) / 64'd8000;
                if (bytes > 64'hFF_FFFF)
                    bytes = 64'hFF_FFFF;
                it.elapsed_us = usec[TIME_W-1:0];
                it.byte_count = bytes[BYTES_W-1:0];
            end
        end
        return it;
    endfunction

    function automatic int idle_choice();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    task automatic send_item(item_t it);
        if (gap_percent != 0 && $urandom_range(0, 99) < gap_percent)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_choices.push_back(predict_selection(it));
    endtask

    task automatic write_alpha(logic [ALPHA_W-1:0] value);
        item_valid <= 1'b0;
        while (pending_choices.size() != 0)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write   <= 1'b0;
        model_alpha = value;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_choices.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat, expected none, actual %0h",
                         $time, result);
            end
            else
            begin
                want = pending_choices.pop_front();
                check_field("chosen_rate_kbps", want.chosen_rate_kbps, result.chosen_rate_kbps);
                check_field("throughput_q8", want.throughput_q8, result.throughput_q8);
                check_field("entry_count", want.entry_count, result.entry_count);
                check_field("table_full_error", want.table_full_error,
                            result.table_full_error);
            end
        end
        if (stall_percent == 0)
        begin
            recv_left = 0;
            recv_hold = 1'b0;
        end
        else
        begin
            if (recv_left == 0)
            begin
                recv_hold = $urandom_range(0, 99) < stall_percent;
                recv_left = recv_hold ? $urandom_range(1, 10) : $urandom_range(1, 20);
            end
            recv_left--;
        end
        result_stall <= recv_hold;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("adaptive_bitrate_selector test failed");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_item(make_item(CMD_MANIFEST, RATE_W'($urandom), BYTES_W'($urandom), $urandom));
        send_item(make_item(CMD_MEASURE, RATE_W'($urandom), 24'hFF_FFFF, 32'd0));
        send_item(make_item(CMD_UNKNOWN, '1, '1, '1));
        send_item(make_item(CMD_MEASURE, '0, 24'd0, '1));
    endtask

    task automatic test_sorted_insert();
        send_item(make_add(20'hF_FFFF));
        send_item(make_add(20'd500));
        send_item(make_add(20'd300));
        // equal rate lands after the one already held
        send_item(make_add(20'd500));
        send_item(make_add(20'd700));
    endtask

    task automatic test_manifest_seed();
        send_item(make_item(CMD_MANIFEST, '0, '0, '0));
    endtask

    task automatic test_measure_extremes();
        write_alpha(ALPHA_ONE);
        send_item(make_item(CMD_MEASURE, RATE_W'($urandom), 24'hFF_FFFF, 32'd1));
        send_item(make_item(CMD_MEASURE, RATE_W'($urandom), 24'd999, 32'hFFFF_FFFF));
        send_item(make_item(CMD_MEASURE, RATE_W'($urandom), 24'd124, 32'd1000));
        send_item(make_item(CMD_MEASURE, RATE_W'($urandom), 24'd1000, 32'd8));
    endtask

    task automatic test_alpha_extremes();
        write_alpha(17'd0);
        send_item(make_item(CMD_MEASURE, RATE_W'($urandom), 24'hFF_FFFF, 32'd100));
        write_alpha(17'h1_FFFF);
        send_item(make_item(CMD_MEASURE, RATE_W'($urandom), 24'h80_0000, 32'd5000));
        write_alpha(17'd1);
        send_item(make_item(CMD_MEASURE, RATE_W'($urandom), 24'd0, 32'd0));
    endtask

    task automatic test_random_traffic(bit hold_fill);
        int seg;
        int n;
        logic [ALPHA_W-1:0] alpha;
        for (seg = 0; seg < 4; seg++)
        begin
            case (segment_index)
                0:       alpha = ALPHA_RESET;
                1:       alpha = 17'd0;
                2:       alpha = ALPHA_ONE;
                3:       alpha = 17'h1_FFFF;
                4:       alpha = ALPHA_ONE + 17'd1;
                5:       alpha = ALPHA_W'($urandom_range(1, 65535));
                6:       alpha = 17'd65535;
                default: alpha = ALPHA_W'($urandom_range(0, 131071));
            endcase
            segment_index++;
            write_alpha(alpha);
            gap_percent   = idle_choice();
            stall_percent = idle_choice();
            for (n = 0; n < SEGMENT_ITEMS; n++)
                send_item(random_item(hold_fill));
        end
    endtask

    task automatic test_full_table();
        send_item(make_add(20'd0));
        while (model_count < ABRS_MAX_RATES)
            send_item(make_add(RATE_W'($urandom_range(1, 1048575))));
        send_item(make_add(RATE_W'($urandom)));
        send_item(make_item(CMD_MANIFEST, RATE_W'($urandom), BYTES_W'($urandom), $urandom));
    endtask

    task automatic test_quiet_traffic();
        int n;
        write_alpha(ALPHA_W'($urandom_range(0, 131071)));
        gap_percent   = 0;
        stall_percent = 0;
        for (n = 0; n < QUIET_ITEMS; n++)
            send_item(random_item(1'b0));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_data      = '0;
        item_valid    = 1'b0;
        item          = '0;
        result_stall  = 1'b0;
        model_count   = 0;
        model_tput    = '0;
        model_alpha   = ALPHA_RESET;
        error_count   = 0;
        gap_percent   = 30;
        stall_percent = 30;
        segment_index = 0;
        recv_left     = 0;
        recv_hold     = 1'b0;
        quiet_cycles  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_sorted_insert();
        test_manifest_seed();
        test_measure_extremes();
        test_alpha_extremes();
        test_random_traffic(1'b1);
        test_full_table();
        test_random_traffic(1'b0);
        test_quiet_traffic();

        item_valid <= 1'b0;
        while (pending_choices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("adaptive_bitrate_selector test passed");
        else
            $display("adaptive_bitrate_selector test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/abrs_pkg.sv
hw/rtl/abrs_meas.sv
hw/rtl/adaptive_bitrate_selector.sv
verif/testbench.sv
